// ===== hw/rtl/source_address_port_filter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Source address / port filter - assertion macros
// Shared property wrappers, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SOURCE_ADDRESS_PORT_FILTER_CORE_MACROS_SVH
`define SOURCE_ADDRESS_PORT_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define SAPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sapf_pkg.sv =====
// ----------------------------------------------------------------------------
// Source address / port filter - package
// Sizes, codes and shared types of the filter pipeline.
// ----------------------------------------------------------------------------
package sapf_pkg;

  localparam int MAX_RULES   = 128;
  localparam int RULE_IDX_W  = $clog2(MAX_RULES);
  localparam int CNT_W       = $clog2(MAX_RULES + 1);
  localparam int GROUP_W     = 16;
  localparam int N_GROUPS    = MAX_RULES / GROUP_W;

  localparam int FUNC_W      = 1;
  localparam int PROTO_W     = 8;
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 16;
  localparam int ENTRY_IDX_W = 7;
  localparam int MODE_W      = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  localparam logic [FUNC_W-1:0]    FUNC_CLASSIFY = 1'b0;
  localparam logic [FUNC_W-1:0]    FUNC_WRITE    = 1'b1;

  localparam logic [PROTO_W-1:0]   PROTO_TCP     = 8'd6;
  localparam logic [PROTO_W-1:0]   PROTO_UDP     = 8'd17;

  localparam logic [MODE_W-1:0]    MODE_BLOCK    = 2'd0;
  localparam logic [MODE_W-1:0]    MODE_ALLOW    = 2'd1;
  localparam logic [MODE_W-1:0]    MODE_OFF      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 1'b1;

  // per-stage control travelling with each word
  typedef struct packed {
    logic vld;    // stage holds a word
    logic wr;     // rule write word (no result)
    logic is_ip;  // word carrying TCP or UDP
  } ctl_t;

endpackage

// ===== hw/rtl/sapf_if.sv =====
// ----------------------------------------------------------------------------
// Source address / port filter - channel interfaces
// Valid/ready channels for input words and verdict words.
// ----------------------------------------------------------------------------
interface sapf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [sapf_pkg::FUNC_W-1:0]           func;
  logic [sapf_pkg::PROTO_W-1:0]          protocol;
  logic [sapf_pkg::ADDR_W-1:0]           src_addr;
  logic [sapf_pkg::PORT_W-1:0]           src_port;
  logic [sapf_pkg::ENTRY_IDX_W-1:0]      entry_index;
  logic [sapf_pkg::ADDR_W-1:0]           entry_addr;
  logic [sapf_pkg::PORT_W-1:0]           entry_port;

  modport source (
    output valid, func, protocol, src_addr, src_port, entry_index, entry_addr, entry_port,
    input  ready
  );
  modport sink (
    input  valid, func, protocol, src_addr, src_port, entry_index, entry_addr, entry_port,
    output ready
  );
endinterface

interface sapf_out_if;
  logic valid;
  logic ready;
  logic accept;
  logic matched;

  modport source (output valid, accept, matched, input ready);
  modport sink   (input valid, accept, matched, output ready);
endinterface

// ===== hw/rtl/source_address_port_filter_core.sv =====
// ----------------------------------------------------------------------------
// Source address / port filter - top level
// Classifies packet headers against a rule table of address/port pairs.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  ---------+-----+--------------------------------------------------------
//  in_ch    | in  | func, protocol, src_addr, src_port, entry_index/addr/port
//  out_ch   | out | accept, matched (one word per classify word only)
//  cfg_*    | in  | write-only: filter_mode (idx 0), rule_count (idx 1)
//
//  One word accepted per cycle while out_ch is not stalled; a classify word's
//  verdict passes input reg, rule compare, group OR and verdict reg in turn.
//  All rule slots are compared in parallel by per-slot comparators.
//  Rule writes take effect as they leave stage 1 and produce no verdict.
//  Reset clears the pipeline valid bits and the registers (mode off, count 0);
//  rule slots are not cleared.
//  A stall on out_ch freezes every stage together; in_ch.ready follows it.
// ----------------------------------------------------------------------------
`include "source_address_port_filter_core_macros.svh"

module source_address_port_filter_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  sapf_in_if.sink                               in_ch,
  sapf_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [sapf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sapf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  // configuration
  logic [sapf_pkg::MODE_W-1:0]      mode_r;
  logic [sapf_pkg::CNT_W-1:0]       count_r;
  logic [sapf_pkg::CNT_W-1:0]       count_nxt;

  // pipeline enable: whole pipe moves unless the output word is stuck
  logic                             adv;

  // stage 1: registered input word
  sapf_pkg::ctl_t                   s1_ctl_r;
  sapf_pkg::ctl_t                   s1_ctl_nxt;
  logic [sapf_pkg::ADDR_W-1:0]      s1_addr_r;
  logic [sapf_pkg::PORT_W-1:0]      s1_port_r;
  logic [sapf_pkg::ENTRY_IDX_W-1:0] s1_eidx_r;
  logic [sapf_pkg::ADDR_W-1:0]      s1_eaddr_r;
  logic [sapf_pkg::PORT_W-1:0]      s1_eport_r;

  // stage 2: per-slot hits
  sapf_pkg::ctl_t                   s2_ctl;
  logic [sapf_pkg::MAX_RULES-1:0]   s2_hit;

  // stage 3: group hits
  sapf_pkg::ctl_t                   s3_ctl;
  logic [sapf_pkg::N_GROUPS-1:0]    s3_grp;

  // output register
  logic                             out_valid_r;
  logic                             out_accept_r;
  logic                             out_matched_r;
  logic                             hit_any;
  logic                             accept_nxt;

  // -------------------------------------------------------------------------
  // configuration registers; rule count saturates at the table depth
  // -------------------------------------------------------------------------
  assign count_nxt = (cfg_wdata > sapf_pkg::CFG_DATA_W'(sapf_pkg::MAX_RULES))
                   ? sapf_pkg::CNT_W'(sapf_pkg::MAX_RULES)
                   : sapf_pkg::CNT_W'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= sapf_pkg::MODE_OFF;
      count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sapf_pkg::CFG_IDX_MODE:  mode_r  <= cfg_wdata[sapf_pkg::MODE_W-1:0];
        sapf_pkg::CFG_IDX_COUNT: count_r <= count_nxt;
        default: ;
      endcase
    end
  end

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // -------------------------------------------------------------------------
  // stage 1
  // -------------------------------------------------------------------------
  always_comb begin
    s1_ctl_nxt.vld   = in_ch.valid;
    s1_ctl_nxt.wr    = (in_ch.func == sapf_pkg::FUNC_WRITE);
    s1_ctl_nxt.is_ip = (in_ch.protocol == sapf_pkg::PROTO_TCP)
                    || (in_ch.protocol == sapf_pkg::PROTO_UDP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r  <= in_ch.src_addr;
      s1_port_r  <= in_ch.src_port;
      s1_eidx_r  <= in_ch.entry_index;
      s1_eaddr_r <= in_ch.entry_addr;
      s1_eport_r <= in_ch.entry_port;
    end
  end

  // -------------------------------------------------------------------------
  // stage 2: rule slots and comparators
  // -------------------------------------------------------------------------
  sapf_rule_array u_rules (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .s1_ctl     (s1_ctl_r),
    .key_addr   (s1_addr_r),
    .key_port   (s1_port_r),
    .wr_idx     (s1_eidx_r),
    .wr_addr    (s1_eaddr_r),
    .wr_port    (s1_eport_r),
    .rule_count (count_r),
    .s2_ctl_r   (s2_ctl),
    .hit_r      (s2_hit)
  );

  // -------------------------------------------------------------------------
  // stage 3: OR per slot group
  // -------------------------------------------------------------------------
  sapf_hit_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s2_ctl   (s2_ctl),
    .hit      (s2_hit),
    .s3_ctl_r (s3_ctl),
    .grp_r    (s3_grp)
  );

  // -------------------------------------------------------------------------
  // stage 4: verdict. Non-TCP/UDP always passes with no match (hits are
  // already gated off); unused mode 3 behaves as filtering off.
  // -------------------------------------------------------------------------
  assign hit_any = |s3_grp;

  always_comb begin
    accept_nxt = 1'b1;
    if (s3_ctl.is_ip) begin
      case (mode_r)
        sapf_pkg::MODE_BLOCK: accept_nxt = !hit_any;
        sapf_pkg::MODE_ALLOW: accept_nxt = hit_any;
        default:              accept_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_accept_r  <= accept_nxt;
      out_matched_r <= hit_any;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.accept  = out_accept_r;
  assign out_ch.matched = out_matched_r;

  `SAPF_ASSERT_NEXT(a_s3_hold, s3_ctl.vld && !adv, s3_ctl.vld && $stable(s3_grp), "stage 3 word changed while stalled")
  `SAPF_ASSERT_NOW(a_nonip_nohit, s3_ctl.vld && !s3_ctl.is_ip, s3_grp == '0, "non TCP/UDP word carries a rule hit")
  `SAPF_ASSERT_NEXT(a_s3_to_out, adv && s3_ctl.vld, out_valid_r, "stage 3 word lost on the way to the output")

endmodule

// ===== hw/rtl/sapf_rule_array.sv =====
// ----------------------------------------------------------------------------
// Source address / port filter - rule array
// Rule slots in flops, each with its own address/port comparator.
// ----------------------------------------------------------------------------
`include "source_address_port_filter_core_macros.svh"

module sapf_rule_array (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  sapf_pkg::ctl_t                      s1_ctl,
  input  logic [sapf_pkg::ADDR_W-1:0]         key_addr,
  input  logic [sapf_pkg::PORT_W-1:0]         key_port,
  input  logic [sapf_pkg::ENTRY_IDX_W-1:0]    wr_idx,
  input  logic [sapf_pkg::ADDR_W-1:0]         wr_addr,
  input  logic [sapf_pkg::PORT_W-1:0]         wr_port,
  input  logic [sapf_pkg::CNT_W-1:0]          rule_count,
  output sapf_pkg::ctl_t                      s2_ctl_r,
  output logic [sapf_pkg::MAX_RULES-1:0]      hit_r
);

  logic [sapf_pkg::ADDR_W-1:0] addr_tbl_r [sapf_pkg::MAX_RULES];
  logic [sapf_pkg::PORT_W-1:0] port_tbl_r [sapf_pkg::MAX_RULES];
  logic [sapf_pkg::MAX_RULES-1:0] hit_nxt;
  sapf_pkg::ctl_t s2_ctl_nxt;
  logic cmp_en;
  logic wr_en;

  assign cmp_en = s1_ctl.vld && !s1_ctl.wr && s1_ctl.is_ip;
  // write lands as the word leaves stage 1, so later words see it
  assign wr_en  = adv && s1_ctl.vld && s1_ctl.wr && (int'(wr_idx) < sapf_pkg::MAX_RULES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_tbl_r[wr_idx[sapf_pkg::RULE_IDX_W-1:0]] <= wr_addr;
      port_tbl_r[wr_idx[sapf_pkg::RULE_IDX_W-1:0]] <= wr_port;
    end
  end

  for (genvar i = 0; i < sapf_pkg::MAX_RULES; i++) begin : g_cell
    assign hit_nxt[i] = cmp_en
                     && (sapf_pkg::CNT_W'(i) < rule_count)
                     && (addr_tbl_r[i] == key_addr)
                     && (port_tbl_r[i] == key_port);
  end

  always_comb begin
    s2_ctl_nxt       = s1_ctl;
    s2_ctl_nxt.vld   = s1_ctl.vld && !s1_ctl.wr;  // writes end here
    s2_ctl_nxt.wr    = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s2_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= hit_nxt;
    end
  end

  `SAPF_ASSERT_NEXT(a_wr_no_hit, adv && s1_ctl.vld && s1_ctl.wr, (hit_r == '0) && !s2_ctl_r.vld, "rule write left a hit or a live stage")

endmodule

// ===== hw/rtl/sapf_hit_reduce.sv =====
// ----------------------------------------------------------------------------
// Source address / port filter - hit reduction
// First level of the hit OR tree, one bit per group of rule slots.
// ----------------------------------------------------------------------------
module sapf_hit_reduce (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  sapf_pkg::ctl_t                      s2_ctl,
  input  logic [sapf_pkg::MAX_RULES-1:0]      hit,
  output sapf_pkg::ctl_t                      s3_ctl_r,
  output logic [sapf_pkg::N_GROUPS-1:0]       grp_r
);

  logic [sapf_pkg::N_GROUPS-1:0] grp_nxt;

  for (genvar g = 0; g < sapf_pkg::N_GROUPS; g++) begin : g_grp
    assign grp_nxt[g] = |hit[g*sapf_pkg::GROUP_W +: sapf_pkg::GROUP_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (adv) begin
      s3_ctl_r <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r <= grp_nxt;
    end
  end

endmodule
